// File: hdl/osas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osas_pkg
// Shared sizes, codes and controller/datapath types for the active-set
// engine of the orthogonal segment sweep.
// ----------------------------------------------------------------------------
package osas_pkg;

  localparam int ACTIVE_CAPACITY = 64;
  localparam int COORD_BITS      = 16;
  localparam int RESULT_LIMIT    = 64;
  localparam int ACTION_W        = 2;

  localparam int ADDR_W    = (ACTIVE_CAPACITY > 1) ? $clog2(ACTIVE_CAPACITY) : 1;
  localparam int CNT_W     = $clog2(ACTIVE_CAPACITY + 1);
  localparam int HIT_CNT_W = $clog2(RESULT_LIMIT + 1);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [HIT_CNT_W-1:0]  hit_cnt_t;
  typedef logic [ACTION_W-1:0]   action_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_REMOVE = 2'd1;
  localparam action_t ACT_QUERY  = 2'd2;

  localparam cnt_t     FULL_COUNT = cnt_t'(ACTIVE_CAPACITY);
  localparam hit_cnt_t LAST_HIT   = hit_cnt_t'(RESULT_LIMIT - 1);

  // One table entry: row key and right end of a horizontal segment.
  typedef struct packed {
    coord_t key;
    coord_t row_end;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic  load_op;    // capture the accepted item's payload
    logic  rd_en;      // read table at rd_addr, data valid next cycle
    addr_t rd_addr;
    logic  wr_en;      // write table at wr_addr
    addr_t wr_addr;
    logic  wr_new;     // write the captured entry instead of the read data
    logic  set_ovf;    // set the sticky overflow flag
    logic  push_hit;   // read data is a hit: move it into the pending slot
    logic  flush_hit;  // pending hit is the final one of the query
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic key_gt_y;
    logic entry_match;
    logic key_gt_hi;
    logic key_ge_lo;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: hdl/osas_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osas_in_if
// Sweep event channel: valid/ready handshake with the event payload.
// ----------------------------------------------------------------------------
interface osas_in_if import osas_pkg::*; ();
  logic    valid;
  logic    ready;
  action_t action;
  coord_t  pos_x;
  coord_t  y_first;
  coord_t  y_second;
  coord_t  end_x;

  modport source (output valid, action, pos_x, y_first, y_second, end_x, input ready);
  modport sink   (input valid, action, pos_x, y_first, y_second, end_x, output ready);
endinterface
`default_nettype wire

// File: hdl/osas_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osas_out_if
// Crossing result channel: valid/ready handshake with one reported point.
// ----------------------------------------------------------------------------
interface osas_out_if import osas_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t hit_x;
  coord_t hit_y;
  logic   last;
  logic   overflow;

  modport source (output valid, hit_x, hit_y, last, overflow, input ready);
  modport sink   (input valid, hit_x, hit_y, last, overflow, output ready);
endinterface
`default_nettype wire

// File: hdl/osas_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osas_dpath
// Table memory, captured operands, key comparators and the two-slot
// result stage (pending hit plus output register).
// ----------------------------------------------------------------------------
module osas_dpath import osas_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  input  coord_t   in_pos_x,
  input  coord_t   in_y_first,
  input  coord_t   in_y_second,
  input  coord_t   in_end_x,
  output logic     out_valid,
  input  logic     out_ready,
  output coord_t   out_hit_x,
  output coord_t   out_hit_y,
  output logic     out_last,
  output logic     out_overflow
);

  entry_t mem [ACTIVE_CAPACITY];
  entry_t rdata_r;
  entry_t wdata;

  coord_t op_x_r, op_y_r, op_end_r, op_lo_r, op_hi_r;
  coord_t pend_y_r;
  logic   pend_valid_r;
  logic   out_valid_r;
  coord_t out_x_r, out_y_r;
  logic   out_last_r, out_ovf_r;
  logic   ovf_r;
  logic   move;

  assign wdata = cmd.wr_new ? entry_t'{key: op_y_r, row_end: op_end_r} : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[cmd.rd_addr];
    end
  end

  // The query range is kept ordered so the scan needs no swap later.
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_x_r   <= in_pos_x;
      op_y_r   <= in_y_first;
      op_end_r <= in_end_x;
      op_lo_r  <= (in_y_first < in_y_second) ? in_y_first : in_y_second;
      op_hi_r  <= (in_y_first < in_y_second) ? in_y_second : in_y_first;
    end
  end

  assign stat.key_gt_y    = rdata_r.key > op_y_r;
  assign stat.entry_match = (rdata_r.key == op_y_r) && (rdata_r.row_end == op_end_r);
  assign stat.key_gt_hi   = rdata_r.key > op_hi_r;
  assign stat.key_ge_lo   = rdata_r.key >= op_lo_r;
  assign stat.pend_valid  = pend_valid_r;
  assign stat.out_free    = !out_valid_r || out_ready;

  // A hit is only known to be non-final once the next hit turns up.
  assign move = pend_valid_r && (cmd.push_hit || cmd.flush_hit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      ovf_r        <= 1'b0;
    end else begin
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.push_hit) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.flush_hit) begin
        pend_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_hit) begin
      pend_y_r <= rdata_r.key;
    end
    if (move) begin
      out_x_r    <= op_x_r;
      out_y_r    <= pend_y_r;
      out_last_r <= cmd.flush_hit;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit_x    = out_x_r;
  assign out_hit_y    = out_y_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

endmodule
`default_nettype wire

// File: hdl/osas_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// osas_ctrl
// Sequencer for insert, remove and query scans over the table memory;
// owns the entry count and the scan indexes.
// ----------------------------------------------------------------------------
module osas_ctrl import osas_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  action_t  in_action,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_RFIND,
    ST_RSHIFT,
    ST_QSCAN,
    ST_QFLUSH
  } state_t;

  state_t   state_r, state_nxt;
  cnt_t     idx_r, idx_nxt;
  cnt_t     didx_r, didx_nxt;
  cnt_t     count_r, count_nxt;
  hit_cnt_t hits_r, hits_nxt;
  logic     rdv_r, rdv_nxt;

  cnt_t idx_m1, idx_m2, didx_m1;
  logic rd_go, hit, stall, stop_scan;

  assign idx_m1  = idx_r - cnt_t'(1);
  assign idx_m2  = idx_r - cnt_t'(2);
  assign didx_m1 = didx_r - cnt_t'(1);
  assign rd_go   = idx_r < count_r;

  assign hit       = rdv_r && stat.key_ge_lo && !stat.key_gt_hi;
  assign stall     = hit && stat.pend_valid && !stat.out_free;
  assign stop_scan = (rdv_r && stat.key_gt_hi) || (hit && (hits_r == LAST_HIT));

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    didx_nxt  = didx_r;
    count_nxt = count_r;
    hits_nxt  = hits_r;
    rdv_nxt   = rdv_r;
    cmd       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          idx_nxt     = '0;
          rdv_nxt     = 1'b0;
          hits_nxt    = '0;
          case (in_action)
            ACT_INSERT: begin
              if (count_r == FULL_COUNT) begin
                cmd.set_ovf = 1'b1;
              end else begin
                idx_nxt   = count_r;
                state_nxt = ST_INS;
              end
            end
            ACT_REMOVE: state_nxt = ST_RFIND;
            ACT_QUERY:  state_nxt = ST_QSCAN;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end

      // Walk down from the free slot, moving larger keys up by one.
      ST_INS: begin
        cmd.wr_addr = idx_r[ADDR_W-1:0];
        if (!rdv_r) begin
          if (idx_r == '0) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_new = 1'b1;
            count_nxt  = count_r + cnt_t'(1);
            state_nxt  = ST_IDLE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_m1[ADDR_W-1:0];
            rdv_nxt     = 1'b1;
          end
        end else if (stat.key_gt_y) begin
          cmd.wr_en = 1'b1;
          idx_nxt   = idx_m1;
          if (idx_r == cnt_t'(1)) begin
            rdv_nxt = 1'b0;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = idx_m2[ADDR_W-1:0];
          end
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_new = 1'b1;
          count_nxt  = count_r + cnt_t'(1);
          rdv_nxt    = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      ST_RFIND: begin
        cmd.rd_addr = idx_r[ADDR_W-1:0];
        rdv_nxt     = rd_go;
        if (rd_go) begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + cnt_t'(1);
          didx_nxt  = idx_r;
        end
        if (rdv_r && stat.entry_match) begin
          if (rd_go) begin
            state_nxt = ST_RSHIFT;
          end else begin
            count_nxt = count_r - cnt_t'(1);
            state_nxt = ST_IDLE;
          end
        end else if (!rd_go) begin
          state_nxt = ST_IDLE;
        end
      end

      // Each read entry drops one slot toward the removed one.
      ST_RSHIFT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = didx_m1[ADDR_W-1:0];
        cmd.rd_addr = idx_r[ADDR_W-1:0];
        rdv_nxt     = rd_go;
        if (rd_go) begin
          cmd.rd_en = 1'b1;
          idx_nxt   = idx_r + cnt_t'(1);
          didx_nxt  = idx_r;
        end else begin
          count_nxt = count_r - cnt_t'(1);
          state_nxt = ST_IDLE;
        end
      end

      ST_QSCAN: begin
        cmd.rd_addr = idx_r[ADDR_W-1:0];
        if (!stall) begin
          if (hit) begin
            cmd.push_hit = 1'b1;
            hits_nxt     = hits_r + hit_cnt_t'(1);
          end
          if (stop_scan || !rd_go) begin
            rdv_nxt   = 1'b0;
            state_nxt = ST_QFLUSH;
          end else begin
            cmd.rd_en = 1'b1;
            idx_nxt   = idx_r + cnt_t'(1);
            rdv_nxt   = 1'b1;
          end
        end
      end

      ST_QFLUSH: begin
        if (!stat.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.flush_hit = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      didx_r  <= '0;
      count_r <= '0;
      hits_r  <= '0;
      rdv_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      didx_r  <= didx_nxt;
      count_r <= count_nxt;
      hits_r  <= hits_nxt;
      rdv_r   <= rdv_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/orthogonal_sweep_active_set.sv
`default_nettype none
// ----------------------------------------------------------------------------
// orthogonal_sweep_active_set
// Active-set engine of an orthogonal segment-intersection sweep: keeps the
// horizontal segments crossing the sweep line in row order and reports the
// rows that each vertical segment crosses.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake     Carries
//   in_ch     sink       valid/ready   action, pos_x, y_first, y_second, end_x
//   out_ch    source     valid/ready   hit_x, hit_y, last, overflow
//
// One item is worked on at a time; the table is a single-port-read,
// single-port-write memory read one entry per cycle while the query scan
// is not stalled, and that port sets the pace. An insert walks down the
// stored entries with a larger row, a remove walks every entry in the
// table, and a query walks the entries up to the top of its range or its
// result limit, then closes the last result. An insert into a full table
// is dropped and sets the overflow flag.
// Reset (synchronous, active low) empties the table and clears the overflow
// flag at once; no clearing pass is needed. A stalled result channel holds
// the query scan only when a new hit finds both result slots occupied, and
// holds the closing cycle until the output register frees.
// ----------------------------------------------------------------------------
module orthogonal_sweep_active_set import osas_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  osas_in_if.sink   in_ch,
  osas_out_if.source out_ch
);

  // The controller sequences table walks; the datapath holds the table,
  // the operands of the current item and the result registers.
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     ctl_ready;

  osas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (ctl_ready),
    .in_action (in_ch.action),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Results leave through a pending slot and an output register, so the
  // final hit of a query can be marked last when the scan closes.
  logic   dp_out_valid;
  coord_t dp_hit_x, dp_hit_y;
  logic   dp_last, dp_overflow;

  osas_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_pos_x     (in_ch.pos_x),
    .in_y_first   (in_ch.y_first),
    .in_y_second  (in_ch.y_second),
    .in_end_x     (in_ch.end_x),
    .out_valid    (dp_out_valid),
    .out_ready    (out_ch.ready),
    .out_hit_x    (dp_hit_x),
    .out_hit_y    (dp_hit_y),
    .out_last     (dp_last),
    .out_overflow (dp_overflow)
  );

  assign in_ch.ready     = ctl_ready;
  assign out_ch.valid    = dp_out_valid;
  assign out_ch.hit_x    = dp_hit_x;
  assign out_ch.hit_y    = dp_hit_y;
  assign out_ch.last     = dp_last;
  assign out_ch.overflow = dp_overflow;

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sweep active-set engine. A queue of sweep events
// (directed corner cases, a fill-to-overflow burst and random traffic) feeds a
// clocked driver. A clocked monitor checks every reported crossing against a
// behavioral copy of the row table, under several sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import osas_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  // This limit leaves a wide margin over the slowest good run: a full remove
  // scan with random gaps on top.
  localparam int STALL_LIMIT  = 3000;
  // Long enough for a query over a full table to close.
  localparam int DRAIN_CYCLES = 150;

  // Action code 3 has no meaning; the block must ignore it.
  localparam action_t ACT_RESERVED = 2'd3;

  typedef struct {
    action_t action;
    coord_t  pos_x;
    coord_t  y_first;
    coord_t  y_second;
    coord_t  end_x;
  } sweep_event_t;

  // One expected crossing, stamped with the cycle in which its event was taken.
  typedef struct {
    coord_t hit_x;
    coord_t hit_y;
    logic   last;
    logic   overflow;
    int     taken_cycle;
  } crossing_t;

  logic clk = 1'b0;
  logic rst_n;

  osas_in_if  in_ch ();
  osas_out_if out_ch ();

  orthogonal_sweep_active_set dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Events waiting to be presented. The front entry stays in the queue while
  // it is on the bus and is popped only when it is accepted.
  sweep_event_t pending_events[$];
  // Crossings that the block still owes, oldest first.
  crossing_t    crossings_due[$];

  // Behavioral copy of the active table, kept in row order.
  coord_t table_key [ACTIVE_CAPACITY];
  coord_t table_end [ACTIVE_CAPACITY];
  int     table_count = 0;
  logic   table_ovf = 1'b0;

  // Shadow of the live segments, used only to steer stimulus toward removes
  // that actually match an entry.
  coord_t live_rows[$];
  coord_t live_ends[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int quiet_cycles   = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Applies one accepted event to the table copy and queues the crossings
  // it should produce.
  task automatic predict_crossings(input sweep_event_t ev, input int stamp);
    int        pos;
    coord_t    lo;
    coord_t    hi;
    int        hit_idx[$];
    crossing_t c;
    case (ev.action)
      ACT_INSERT: begin
        if (table_count >= ACTIVE_CAPACITY) begin
          // Full table: the insert is dropped and the flag sticks.
          table_ovf = 1'b1;
        end else begin
          pos = 0;
          // Equal rows go after the existing ones, so insertion order holds.
          while (pos < table_count && table_key[pos] <= ev.y_first) pos++;
          for (int i = table_count; i > pos; i--) begin
            table_key[i] = table_key[i-1];
            table_end[i] = table_end[i-1];
          end
          table_key[pos] = ev.y_first;
          table_end[pos] = ev.end_x;
          table_count++;
        end
      end
      ACT_REMOVE: begin
        pos = 0;
        while (pos < table_count &&
               !(table_key[pos] == ev.y_first && table_end[pos] == ev.end_x)) pos++;
        // A remove that matches nothing leaves the table alone.
        if (pos < table_count) begin
          for (int i = pos; i + 1 < table_count; i++) begin
            table_key[i] = table_key[i+1];
            table_end[i] = table_end[i+1];
          end
          table_count--;
        end
      end
      ACT_QUERY: begin
        lo = (ev.y_first < ev.y_second) ? ev.y_first : ev.y_second;
        hi = (ev.y_first < ev.y_second) ? ev.y_second : ev.y_first;
        for (int i = 0; i < table_count && hit_idx.size() < RESULT_LIMIT; i++) begin
          if (table_key[i] > hi) break;
          if (table_key[i] >= lo) hit_idx = {hit_idx, i};
        end
        foreach (hit_idx[k]) begin
          c.hit_x       = ev.pos_x;
          c.hit_y       = table_key[hit_idx[k]];
          c.last        = (k == hit_idx.size() - 1);
          c.overflow    = table_ovf;
          c.taken_cycle = stamp;
          crossings_due = {crossings_due, c};
        end
      end
      default: begin
        // Reserved action: nothing happens.
      end
    endcase
  endtask

  task automatic queue_event(input action_t act, input coord_t px, input coord_t y1,
                             input coord_t y2, input coord_t ex);
    sweep_event_t ev;
    ev.action   = act;
    ev.pos_x    = px;
    ev.y_first  = y1;
    ev.y_second = y2;
    ev.end_x    = ex;
    pending_events = {pending_events, ev};
  endtask

  // Fields an event does not use still carry random bits.
  task automatic queue_insert(input coord_t y, input coord_t ex);
    if (live_rows.size() < ACTIVE_CAPACITY) begin
      live_rows = {live_rows, y};
      live_ends = {live_ends, ex};
    end
    queue_event(ACT_INSERT, coord_t'($urandom), y, coord_t'($urandom), ex);
  endtask

  task automatic queue_remove(input coord_t y, input coord_t ex);
    int k;
    k = 0;
    while (k < live_rows.size() && !(live_rows[k] == y && live_ends[k] == ex)) k++;
    if (k < live_rows.size()) begin
      live_rows.delete(k);
      live_ends.delete(k);
    end
    queue_event(ACT_REMOVE, coord_t'($urandom), y, coord_t'($urandom), ex);
  endtask

  task automatic queue_query(input coord_t px, input coord_t ya, input coord_t yb);
    queue_event(ACT_QUERY, px, ya, yb, coord_t'($urandom));
  endtask

  // Rows cluster on a few values so that queries find hits and equal rows
  // pile up, with the extremes and fully random rows mixed in.
  function automatic coord_t pick_row();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 45) return coord_t'($urandom_range(15) << 12);
    return coord_t'($urandom);
  endfunction

  task automatic queue_random(input int count);
    int     r;
    int     k;
    int     t;
    coord_t lo;
    coord_t hi;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40) begin
        // A small end x now and then makes same-row, wrong-end removes likely.
        queue_insert(pick_row(), (r < 15) ? coord_t'($urandom_range(3)) : coord_t'($urandom));
      end else if (r < 70) begin
        if (live_rows.size() > 0 && r < 62) begin
          k = $urandom_range(live_rows.size() - 1);
          queue_remove(live_rows[k], (r < 58) ? live_ends[k] : coord_t'($urandom_range(3)));
        end else begin
          queue_remove(pick_row(), coord_t'($urandom));
        end
      end else if (r < 95) begin
        lo = pick_row();
        t  = $urandom_range(9);
        if (t < 2) hi = lo;
        else if (t < 6) hi = lo + coord_t'($urandom_range(16'h2000));
        else hi = coord_t'($urandom);
        // Ends arrive in either order; the block must sort them itself.
        if ($urandom_range(2) == 0) queue_query(coord_t'($urandom), hi, lo);
        else queue_query(coord_t'($urandom), lo, hi);
      end else begin
        queue_event(ACT_RESERVED, coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom));
      end
    end
  endtask

  // Holds the sender back until every queued event is taken and every
  // expected crossing has come out.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || crossings_due.size() != 0);
  endtask

  // Driver: presents the front of the pending queue, holds it until it is
  // accepted, and feeds each accepted event to the predictor.
  always @(posedge clk) begin
    logic give;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_crossings(pending_events[0], cycle_count);
        void'(pending_events.pop_front());
      end
      // An offered item is never withdrawn before it is taken.
      give = (in_ch.valid && !in_ch.ready) ||
             (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct);
      in_ch.valid <= give;
      if (give) begin
        in_ch.action   <= pending_events[0].action;
        in_ch.pos_x    <= pending_events[0].pos_x;
        in_ch.y_first  <= pending_events[0].y_first;
        in_ch.y_second <= pending_events[0].y_second;
        in_ch.end_x    <= pending_events[0].end_x;
      end
    end
  end

  // Monitor: checks each accepted crossing against the oldest one owed.
  // An expectation stamped in this very cycle belongs to an event taken at
  // this edge and cannot have produced a result yet, so it is not eligible;
  // that keeps the check independent of the order of the two blocks.
  always @(posedge clk) begin
    crossing_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (crossings_due.size() == 0 || crossings_due[0].taken_cycle == cycle_count) begin
          report_mismatch($sformatf("unexpected crossing x=%h y=%h last=%b ovf=%b",
                                    out_ch.hit_x, out_ch.hit_y, out_ch.last, out_ch.overflow));
        end else begin
          want = crossings_due.pop_front();
          if ({out_ch.hit_x, out_ch.hit_y, out_ch.last, out_ch.overflow} !==
              {want.hit_x, want.hit_y, want.last, want.overflow}) begin
            report_mismatch($sformatf(
              "crossing x=%h y=%h last=%b ovf=%b, expected x=%h y=%h last=%b ovf=%b",
              out_ch.hit_x, out_ch.hit_y, out_ch.last, out_ch.overflow,
              want.hit_x, want.hit_y, want.last, want.overflow));
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Cycle counter and watchdog: the run ends if no item moves on either
  // channel for too long.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_INSERT;
    in_ch.pos_x     = '0;
    in_ch.y_first   = '0;
    in_ch.y_second  = '0;
    in_ch.end_x     = '0;
    out_ch.ready    = 1'b0;

    // Directed opening, run with no idling on either side.
    // Query and remove on an empty table, and the reserved code.
    queue_query(16'h0000, 16'h0000, 16'hFFFF);
    queue_remove(16'h1234, 16'h5678);
    queue_event(ACT_RESERVED, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    // Extreme rows, then equal rows that must stay in insertion order,
    // including an exact duplicate.
    queue_insert(16'h0000, 16'h0000);
    queue_insert(16'hFFFF, 16'hFFFF);
    queue_insert(16'd100, 16'd5);
    queue_insert(16'd100, 16'd7);
    queue_insert(16'd100, 16'd5);
    // Full range with swapped ends, a single-row range, and an empty range.
    queue_query(16'hFFFF, 16'hFFFF, 16'h0000);
    queue_query(16'h1234, 16'd100, 16'd100);
    queue_query(16'h5A5A, 16'd200, 16'd300);
    // A remove with the right row but no matching end, then a real one.
    queue_remove(16'd100, 16'd6);
    queue_remove(16'd100, 16'd5);
    queue_query(16'hA5A5, 16'h0000, 16'd100);
    queue_event(ACT_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Zero-width ranges at both ends of the coordinate space.
    queue_query(16'h0000, 16'h0000, 16'h0000);
    queue_query(16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_remove(16'hFFFF, 16'hFFFF);
    queue_remove(16'h0000, 16'h0000);
    queue_query(16'h0F0F, 16'hFFFF, 16'h0000);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Settings change only on the falling edge, away from the driving edge.
    @(negedge clk);
    queue_random(50);
    wait_drained();

    // Sender idles often. The drain above is the pause that lets every
    // owed crossing come out before new traffic starts.
    send_idle_pct = 46;
    queue_random(50);
    wait_drained();

    // Receiver stalls. Fill the table past capacity so the overflow flag
    // rises, then read back all sixty-four rows against a stalling receiver.
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    while (live_rows.size() < ACTIVE_CAPACITY) queue_insert(pick_row(), coord_t'($urandom));
    repeat (3) queue_insert(pick_row(), coord_t'($urandom));
    queue_query(coord_t'($urandom), 16'hFFFF, 16'h0000);
    queue_query(coord_t'($urandom), 16'h0000, 16'hFFFF);
    queue_random(30);
    wait_drained();

    // Both sides idle.
    send_idle_pct  = 38;
    recv_stall_pct = 38;
    queue_random(40);
    wait_drained();

    // A last stretch with no idling at all.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(20);
    wait_drained();

    // Let any stray crossing surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && crossings_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
